// ===== hdl/zsad_pkg.sv =====
// Package for the zoomed sprite attribute decoder.
// Request structs, sequencer states and constants; no dependencies.

package zsad_pkg;

    localparam int DIV_BITS      = 24;          // quotient width of 0x800000 / f
    localparam int FACTOR_BITS   = 10;
    localparam int EDGE_BITS     = 13;          // an edge reaches 4096
    localparam int OUT_BITS      = 12;
    localparam logic [24:0] EDGE_ROUND = 25'd2048;
    localparam logic [8:0]  Y_ORIGIN   = 9'd256;
    localparam int CTRL_FLIP_X   = 2;
    localparam int CTRL_FLIP_Y   = 3;
    localparam int CTRL_BIG      = 6;

    typedef struct packed {
        logic [7:0] y_byte;
        logic [7:0] code_low;
        logic [7:0] attr_high;
        logic [7:0] x_byte;
        logic [7:0] control_byte;
        logic [7:0] zoom_low;
        logic       last_sprite;
    } sprite_t;

    typedef struct packed {
        logic [11:0] tile_code;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [11:0] width_px;
        logic [11:0] height_px;
        logic        flip_x;
        logic        flip_y;
        logic        draw_valid;
        logic        last_of_sprite;
        logic        end_of_list;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EDGE,
        ST_EMIT
    } state_t;

endpackage

// ===== hdl/zoomed_sprite_attribute_decoder_top.sv =====
// Zoomed sprite attribute decoder, top level.
// Depends on zsad_pkg for the request structs and the sequencer states.
//
// Usage:
//   sprite channel: one attribute entry per request (sprite, sprite_valid,
//   sprite_stall). sprite_stall is high whenever an entry is being worked on.
//   cmd channel: one or four tile draw commands per entry (cmd, cmd_valid,
//   cmd_stall), in row order top left, top right, bottom left, bottom right.
//   cfg_we / cfg_data write the sprite bank bit; write only while idle.
// Timing:
//   The zoom value 0x800000 / f comes from a restoring divider that yields
//   one quotient bit per cycle; the edges are then formed in ST_EDGE.
//   The commands are offered in ST_EMIT, one command per cycle while
//   cmd_stall is low; after the last is taken the sequencer returns to idle
//   before it accepts the next entry, so entries do not overlap. A zero
//   zoom factor skips the divider and offers its single not-valid command
//   in the cycle after acceptance.
// Reset:
//   rst_n clears the sequencer to idle and the bank bit to 0.
// Stall:
//   While cmd_stall is high the offered command holds and the command sequence does not advance.

module zoomed_sprite_attribute_decoder_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_data,
    input  zsad_pkg::sprite_t sprite,
    input  logic              sprite_valid,
    output logic              sprite_stall,
    output zsad_pkg::cmd_t    cmd,
    output logic              cmd_valid,
    input  logic              cmd_stall
);

    zsad_pkg::state_t  state_reg, state_next;
    zsad_pkg::sprite_t entry_reg, entry_next;
    logic              bank_reg, bank_next;
    logic [zsad_pkg::DIV_BITS-1:0]      quot_reg, quot_next;
    logic [zsad_pkg::FACTOR_BITS:0]     rem_reg, rem_next;
    logic [4:0]                         cnt_reg, cnt_next;
    logic [zsad_pkg::EDGE_BITS-1:0]     e1_reg, e1_next;
    logic [zsad_pkg::EDGE_BITS-1:0]     e2_reg, e2_next;
    logic [1:0]                         quad_reg, quad_next;

    logic [zsad_pkg::FACTOR_BITS-1:0]   factor;
    logic [zsad_pkg::FACTOR_BITS:0]     trial;
    logic                               fits;
    logic [24:0]                        sum1, sum2;
    logic                               big, col, row, csel, rsel, last_cmd;
    logic [zsad_pkg::EDGE_BITS-1:0]     ex0, ex1, ey0, ey1;
    logic [11:0]                        base;
    logic [8:0]                         oy;
    logic [zsad_pkg::EDGE_BITS-1:0]     px, py, wd, ht;

    assign factor = {entry_reg.control_byte[1:0], entry_reg.zoom_low};

    // one restoring step; the dividend 0x800000 has a single one at its top
    assign trial = {rem_reg[zsad_pkg::FACTOR_BITS-1:0], (cnt_reg == 5'd0)};
    assign fits  = (trial >= {1'b0, factor});

    assign sum1 = {1'b0, quot_reg} + zsad_pkg::EDGE_ROUND;
    assign sum2 = {quot_reg, 1'b0} + zsad_pkg::EDGE_ROUND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= zsad_pkg::ST_IDLE;
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        e1_reg    <= e1_next;
        e2_reg    <= e2_next;
        quad_reg  <= quad_next;
    end

    always_comb
    begin
        state_next = state_reg;
        entry_next = entry_reg;
        bank_next  = cfg_we ? cfg_data : bank_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        e1_next    = e1_reg;
        e2_next    = e2_reg;
        quad_next  = quad_reg;
        case (state_reg)
            zsad_pkg::ST_IDLE:
            begin
                if (sprite_valid)
                begin
                    entry_next = sprite;
                    quot_next  = '0;
                    rem_next   = '0;
                    cnt_next   = '0;
                    quad_next  = '0;
                    if ({sprite.control_byte[1:0], sprite.zoom_low} == '0)
                        state_next = zsad_pkg::ST_EMIT;
                    else
                        state_next = zsad_pkg::ST_DIVIDE;
                end
            end
            zsad_pkg::ST_DIVIDE:
            begin
                rem_next  = fits ? (trial - {1'b0, factor}) : trial;
                quot_next = {quot_reg[zsad_pkg::DIV_BITS-2:0], fits};
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'(zsad_pkg::DIV_BITS - 1))
                    state_next = zsad_pkg::ST_EDGE;
            end
            zsad_pkg::ST_EDGE:
            begin
                e1_next    = sum1[24:12];
                e2_next    = sum2[24:12];
                state_next = zsad_pkg::ST_EMIT;
            end
            zsad_pkg::ST_EMIT:
            begin
                if (!cmd_stall)
                begin
                    quad_next = quad_reg + 2'd1;
                    if (last_cmd)
                        state_next = zsad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = zsad_pkg::ST_IDLE;
            end
        endcase
    end

    // quadrant decode, all from registers
    assign big      = entry_reg.control_byte[zsad_pkg::CTRL_BIG];
    assign col      = quad_reg[0];
    assign row      = quad_reg[1];
    assign csel     = big & (col ^ entry_reg.control_byte[zsad_pkg::CTRL_FLIP_X]);
    assign rsel     = big & (row ^ entry_reg.control_byte[zsad_pkg::CTRL_FLIP_Y]);
    assign last_cmd = !big || (quad_reg == 2'd3) || (factor == '0);

    assign ex0 = col ? e1_reg : '0;
    assign ex1 = col ? e2_reg : e1_reg;
    assign ey0 = row ? e1_reg : '0;
    assign ey1 = row ? e2_reg : e1_reg;

    assign base = {4'd0, entry_reg.code_low} + {2'd0, entry_reg.attr_high[7:6], 8'd0}
                + {1'b0, bank_reg, 10'd0};
    assign oy   = zsad_pkg::Y_ORIGIN - {1'b0, entry_reg.y_byte};

    assign px = {5'd0, entry_reg.x_byte} + ex0;
    assign py = {4'd0, oy} + ey0;
    assign wd = ex1 - ex0;
    assign ht = ey1 - ey0;

    always_comb
    begin
        cmd = '0;
        cmd.last_of_sprite = last_cmd;
        cmd.end_of_list    = last_cmd & entry_reg.last_sprite;
        if (factor != '0)
        begin
            cmd.tile_code  = base + {10'd0, rsel, csel};
            cmd.pos_x      = px[zsad_pkg::OUT_BITS-1:0];
            cmd.pos_y      = py[zsad_pkg::OUT_BITS-1:0];
            cmd.width_px   = wd[zsad_pkg::OUT_BITS-1:0];
            cmd.height_px  = ht[zsad_pkg::OUT_BITS-1:0];
            cmd.flip_x     = entry_reg.control_byte[zsad_pkg::CTRL_FLIP_X];
            cmd.flip_y     = entry_reg.control_byte[zsad_pkg::CTRL_FLIP_Y];
            cmd.draw_valid = 1'b1;
        end
    end

    assign cmd_valid    = (state_reg == zsad_pkg::ST_EMIT);
    assign sprite_stall = (state_reg != zsad_pkg::ST_IDLE);

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench for zoomed_sprite_attribute_decoder_top: directed and random sprite requests,
// each checked field by field against a predicted list of draw commands.
// Depends on zsad_pkg and the decoder RTL.

module tb;

    localparam int unsigned ZOOM_NUMERATOR = 32'h0080_0000;
    localparam int unsigned EDGE_SHIFT     = 12;
    localparam int unsigned BANK_STEP      = 1024;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          TAIL_CYCLES    = 40;
    localparam int          CYCLE_LIMIT    = 200000;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_we       = 1'b0;
    logic              cfg_data     = 1'b0;
    zsad_pkg::sprite_t sprite       = '0;
    logic              sprite_valid = 1'b0;
    logic              sprite_stall;
    zsad_pkg::cmd_t    cmd;
    logic              cmd_valid;
    logic              cmd_stall    = 1'b0;

    logic           bank_bit = 1'b0;
    zsad_pkg::cmd_t cmd_expected[$];
    int             errors     = 0;
    bit             no_gaps    = 1'b0;
    int             stall_left = 0;
    int             cycles     = 0;

    zoomed_sprite_attribute_decoder_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .sprite       (sprite),
        .sprite_valid (sprite_valid),
        .sprite_stall (sprite_stall),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned edge_at(int unsigned zoom, int unsigned k);
        return (zoom * k + 32'(zsad_pkg::EDGE_ROUND)) >> EDGE_SHIFT;
    endfunction

    // queues the draw commands one sprite request should produce
    function automatic void predict_commands(zsad_pkg::sprite_t s);
        zsad_pkg::cmd_t c;
        int unsigned    factor, zoom, base, span, row, col;
        int unsigned    ex0, ex1, ey0, ey1, ox, oy;
        logic           fx, fy;
        factor = 32'({s.control_byte[1:0], s.zoom_low});
        fx     = s.control_byte[zsad_pkg::CTRL_FLIP_X];
        fy     = s.control_byte[zsad_pkg::CTRL_FLIP_Y];
        span   = s.control_byte[zsad_pkg::CTRL_BIG] ? 2 : 1;
        if (factor == 0)
        begin
            c = '0;
            c.last_of_sprite = 1'b1;
            c.end_of_list    = s.last_sprite;
            cmd_expected.push_back(c);
            return;
        end
        zoom = ZOOM_NUMERATOR / factor;
        base = int'(s.code_low) + int'(s.attr_high[7:6]) * 256 + BANK_STEP * int'(bank_bit);
        ox   = 32'(s.x_byte);
        oy   = 32'(zsad_pkg::Y_ORIGIN) - 32'(s.y_byte);
        for (row = 0; row < span; row++)
        begin
            ey0 = edge_at(zoom, row);
            ey1 = edge_at(zoom, row + 1);
            for (col = 0; col < span; col++)
            begin
                ex0 = edge_at(zoom, col);
                ex1 = edge_at(zoom, col + 1);
                // quadrant offset mirrors with the flips
                c.tile_code      = 12'(base + (fx ? span - 1 - col : col)
                                       + 2 * (fy ? span - 1 - row : row));
                c.pos_x          = 12'(ox + ex0);
                c.pos_y          = 12'(oy + ey0);
                c.width_px       = 12'(ex1 - ex0);
                c.height_px      = 12'(ey1 - ey0);
                c.flip_x         = fx;
                c.flip_y         = fy;
                c.draw_valid     = 1'b1;
                c.last_of_sprite = (row == span - 1) && (col == span - 1);
                c.end_of_list    = c.last_of_sprite && s.last_sprite;
                cmd_expected.push_back(c);
            end
        end
    endfunction

    function automatic zsad_pkg::sprite_t sprite_entry(logic [7:0] y, logic [7:0] code,
                                                       logic [7:0] attr, logic [7:0] x,
                                                       logic [7:0] ctrl, logic [7:0] zoom,
                                                       logic last);
        return '{y, code, attr, x, ctrl, zoom, last};
    endfunction

    function automatic zsad_pkg::sprite_t random_sprite();
        zsad_pkg::sprite_t s;
        int unsigned       factor, r;
        s.y_byte       = 8'($urandom);
        s.code_low     = 8'($urandom);
        s.attr_high    = 8'($urandom);
        s.x_byte       = 8'($urandom);
        s.control_byte = 8'($urandom);
        r = $urandom_range(99);
        if (r < 5)
            factor = 0;
        else if (r < 20)
            factor = $urandom_range(1, 15);
        else if (r < 45)
            factor = $urandom_range(120, 136);
        else
            factor = $urandom_range(1023);
        s.zoom_low          = factor[7:0];
        s.control_byte[1:0] = factor[9:8];
        s.last_sprite       = ($urandom_range(3) == 0);
        return s;
    endfunction

    function automatic int field_mismatch(string name, logic [11:0] want, logic [11:0] got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1;
    endfunction

    // valid stays high between back-to-back requests; here it is only lowered for a gap
    task automatic send_sprite(zsad_pkg::sprite_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sprite_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sprite       <= s;
        sprite_valid <= 1'b1;
        do
            @(posedge clk);
        while (sprite_stall);
        predict_commands(s);
    endtask

    task automatic settle();
        sprite_valid <= 1'b0;
        while (cmd_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bank(logic value);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        bank_bit = value;
    endtask

    task automatic test_unscaled_and_flips();
        send_sprite(sprite_entry(8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'd128, 1'b0));
        send_sprite(sprite_entry(8'hFF, 8'hFF, 8'hC0, 8'hFF, 8'h40, 8'd128, 1'b0));
        send_sprite(sprite_entry(8'h80, 8'h12, 8'h40, 8'h20, 8'h44, 8'd128, 1'b0));
        send_sprite(sprite_entry(8'h81, 8'h34, 8'h80, 8'h30, 8'h48, 8'd128, 1'b0));
        send_sprite(sprite_entry(8'h82, 8'h56, 8'hC0, 8'h40, 8'h4C, 8'd128, 1'b1));
        send_sprite(sprite_entry(8'h01, 8'h78, 8'h00, 8'h50, 8'h0C, 8'd128, 1'b1));
        // bits that the decoder ignores
        send_sprite(sprite_entry(8'h40, 8'hA5, 8'h3F, 8'h60, 8'hB0, 8'd128, 1'b0));
        send_sprite(sprite_entry(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    endtask

    task automatic test_zoom_extremes();
        // zero factor: one not-valid command, even with the 32x32 bit set
        send_sprite(sprite_entry(8'h20, 8'h11, 8'h80, 8'h22, 8'h4C, 8'h00, 1'b0));
        send_sprite(sprite_entry(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFC, 8'h00, 1'b1));
        send_sprite(sprite_entry(8'h00, 8'h01, 8'h00, 8'hFF, 8'h40, 8'h01, 1'b0));
        send_sprite(sprite_entry(8'h00, 8'h02, 8'h40, 8'hFF, 8'h0C, 8'h01, 1'b1));
        send_sprite(sprite_entry(8'h30, 8'h03, 8'h00, 8'h10, 8'h43, 8'hFF, 1'b0));
        send_sprite(sprite_entry(8'h50, 8'h04, 8'h00, 8'h70, 8'h41, 8'h00, 1'b0));
        send_sprite(sprite_entry(8'h60, 8'h05, 8'h00, 8'h90, 8'h44, 8'd3, 1'b0));
        send_sprite(sprite_entry(8'h70, 8'h06, 8'h00, 8'hA0, 8'h48, 8'd64, 1'b0));
    endtask

    task automatic test_bank_select();
        write_bank(1'b1);
        send_sprite(sprite_entry(8'h90, 8'hFF, 8'hC0, 8'h08, 8'h40, 8'd128, 1'b0));
        send_sprite(sprite_entry(8'h91, 8'hFF, 8'hC0, 8'h09, 8'h4C, 8'd100, 1'b1));
        send_sprite(sprite_entry(8'h92, 8'h10, 8'h40, 8'h0A, 8'h00, 8'h00, 1'b0));
        send_sprite(sprite_entry(8'h93, 8'h00, 8'h00, 8'h0B, 8'h02, 8'h00, 1'b0));
        write_bank(1'b0);
    endtask

    task automatic test_random_traffic(int count);
        for (int i = 0; i < count; i++)
            send_sprite(random_sprite());
    endtask

    task automatic test_back_to_back(int count);
        no_gaps = 1'b1;
        test_random_traffic(count);
        settle();
        no_gaps = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (stall_left == 0)
            stall_left = pick_gap();
        if (stall_left > 0)
        begin
            cmd_stall <= 1'b1;
            stall_left--;
        end
        else
            cmd_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        zsad_pkg::cmd_t want;
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            if (cmd_expected.size() == 0)
            begin
                $display("%0t: unexpected command, expected none, actual tile %0d",
                         $time, cmd.tile_code);
                errors++;
            end
            else
            begin
                want = cmd_expected.pop_front();
                errors += field_mismatch("tile_code", want.tile_code, cmd.tile_code)
                        + field_mismatch("pos_x", want.pos_x, cmd.pos_x)
                        + field_mismatch("pos_y", want.pos_y, cmd.pos_y)
                        + field_mismatch("width_px", want.width_px, cmd.width_px)
                        + field_mismatch("height_px", want.height_px, cmd.height_px)
                        + field_mismatch("flip_x", 12'(want.flip_x), 12'(cmd.flip_x))
                        + field_mismatch("flip_y", 12'(want.flip_y), 12'(cmd.flip_y))
                        + field_mismatch("draw_valid", 12'(want.draw_valid),
                                         12'(cmd.draw_valid))
                        + field_mismatch("last_of_sprite", 12'(want.last_of_sprite),
                                         12'(cmd.last_of_sprite))
                        + field_mismatch("end_of_list", 12'(want.end_of_list),
                                         12'(cmd.end_of_list));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unscaled_and_flips();
        test_zoom_extremes();
        test_bank_select();
        for (int phase = 0; phase < 4; phase++)
        begin
            write_bank(phase % 2 == 1);
            test_random_traffic(30);
        end
        test_back_to_back(20);
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && cmd_expected.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
